@@ rtl/battery_guard_blink_charge_control_defines.svh @@
// ----------------------------------------------------------------------------
// battery guard assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BATTERY_GUARD_BLINK_CHARGE_CONTROL_DEFINES_SVH
`define BATTERY_GUARD_BLINK_CHARGE_CONTROL_DEFINES_SVH

// same-cycle implication
`define BGBC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bgbc same-cycle check failed");

// next-cycle implication
`define BGBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bgbc next-cycle check failed");

`endif

@@ rtl/bgbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bgbc_pkg
// types and constants of the battery guard block
// ----------------------------------------------------------------------------
package bgbc_pkg;

   localparam int PCT_W  = 7;
   localparam int UA_W   = 24;
   localparam int TIME_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_THRESHOLD     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUTDOWN_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUTDOWN_ENABLE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_CTRL_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_CAPACITY      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_CURRENT_UA    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CAPACITY     = 3'd6;

   // register reset values
   localparam logic [PCT_W-1:0]      WARN_THRESHOLD_RST     = 7'd5;
   localparam logic [PCT_W-1:0]      SHUTDOWN_THRESHOLD_RST = 7'd1;
   localparam logic [PCT_W-1:0]      STOP_CAPACITY_RST      = 7'd99;
   localparam logic [CSR_DATA_W-1:0] STOP_CURRENT_UA_RST    = 23'd80000;
   localparam logic [PCT_W-1:0]      START_CAPACITY_RST     = 7'd95;

   // fixed behavior constants
   localparam logic [TIME_W-1:0]      CHECK_GAP          = 32'd60;
   localparam logic [TIME_W-1:0]      WORKAROUND_GAP     = 32'd1200;
   localparam logic signed [UA_W-1:0] CHARGING_UA        = 24'sd100;
   localparam logic [PCT_W-1:0]       UNREADABLE_PERCENT = 7'd50;

   localparam logic [7:0] LED_NORMAL    = 8'd250;
   localparam logic [7:0] LED_BLINK_ON  = 8'd200;
   localparam logic [7:0] LED_BLINK_OFF = 8'd10;
   localparam logic [7:0] LED_NONE      = 8'd0;

   // charger commands
   localparam logic [1:0] CHG_NONE    = 2'd0;
   localparam logic [1:0] CHG_DISABLE = 2'd1;
   localparam logic [1:0] CHG_ENABLE  = 2'd2;

   // timer reload kinds
   localparam logic [1:0] NEXT_KEEP      = 2'd0;
   localparam logic [1:0] NEXT_CHECK     = 2'd1;
   localparam logic [1:0] NEXT_BLINK_ON  = 2'd2;
   localparam logic [1:0] NEXT_BLINK_OFF = 2'd3;

   // charger readback codes
   localparam logic [1:0] STATUS_ENABLED = 2'd1;

   typedef struct packed {
      logic signed [7:0]        battery_percent;
      logic signed [UA_W-1:0]   charge_current_ua;
      logic [1:0]               charger_status;
      logic [TIME_W-1:0]        now_seconds;
   } req_word_type;

   typedef struct packed {
      logic       shutdown_request;
      logic [1:0] charger_write;
      logic       charger_read_error;
      logic       led_write;
      logic [7:0] led_level;
      logic [1:0] next_alarm;
   } rsp_word_type;

endpackage

@@ rtl/bgbc_req_if.sv @@
// ----------------------------------------------------------------------------
// bgbc_req_if
// alarm tick channel: valid, ready and one tick word
// ----------------------------------------------------------------------------
interface bgbc_req_if;
   logic                  valid;
   logic                  ready;
   bgbc_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bgbc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bgbc_rsp_if
// result channel: valid, ready and one result word
// ----------------------------------------------------------------------------
interface bgbc_rsp_if;
   logic                  valid;
   logic                  ready;
   bgbc_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/battery_guard_blink_charge_control.sv @@
// ----------------------------------------------------------------------------
// battery_guard_blink_charge_control
// low-battery shutdown request, charger hysteresis and LED blink sequencer
// ----------------------------------------------------------------------------
// One alarm tick word in gives exactly one result word out. A tick is
// captured in an input register, evaluated by compare logic and placed in
// the result register once that register is free or is being emptied. The
// block takes one word every cycle while the result side is not stalled;
// the state (blink phase, shutdown one-shot flag, last check and
// workaround times) is updated as each word moves into the result register,
// so a following word always sees the state its predecessor left. Ready
// drops only when both the input and result registers hold words and the
// result side is stalled. The user must write registers through the csr
// port only while no word is in flight; the block itself does not enforce
// this.
`include "battery_guard_blink_charge_control_defines.svh"

module battery_guard_blink_charge_control (
   input  logic                                clock,
   input  logic                                reset,
   bgbc_req_if.sink                            req_chan,
   bgbc_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_en,
   input  logic [bgbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bgbc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // blink sequencer states
   localparam logic [1:0] BLINK_IDLE    = 2'd0;
   localparam logic [1:0] BLINK_WAIT_ON = 2'd1;
   localparam logic [1:0] BLINK_LED_ON  = 2'd2;

   // configuration registers
   logic [bgbc_pkg::PCT_W-1:0]      warn_threshold_ff;
   logic [bgbc_pkg::PCT_W-1:0]      shutdown_threshold_ff;
   logic                            shutdown_enable_ff;
   logic                            charge_control_enable_ff;
   logic [bgbc_pkg::PCT_W-1:0]      stop_capacity_ff;
   logic [bgbc_pkg::CSR_DATA_W-1:0] stop_current_ua_ff;
   logic [bgbc_pkg::PCT_W-1:0]      start_capacity_ff;

   // block state
   logic [1:0]                      blink_phase_ff, blink_phase_in;
   logic                            shutdown_warned_ff, shutdown_warned_in;
   logic [bgbc_pkg::TIME_W-1:0]     last_check_time_ff, last_check_time_in;
   logic [bgbc_pkg::TIME_W-1:0]     last_workaround_time_ff, last_workaround_time_in;

   // input register and result register
   logic                            in_valid_ff, in_valid_in;
   bgbc_pkg::req_word_type          in_word_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   bgbc_pkg::rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                            in_advance;
   logic                            req_take;

   // evaluation signals
   logic [bgbc_pkg::PCT_W-1:0]      bat_pct;
   logic signed [bgbc_pkg::UA_W-1:0] ua;
   logic signed [bgbc_pkg::UA_W-1:0] stop_current_s;
   logic [bgbc_pkg::TIME_W-1:0]     check_age;
   logic [bgbc_pkg::TIME_W-1:0]     workaround_age;
   logic                            check_due;
   logic                            workaround_due;
   logic                            charger_on;
   logic                            warned_mid;

   // ---------------------------------------------------------------------------
   // handshake: the input register advances whenever the result register is
   // free or is being emptied in this cycle
   // ---------------------------------------------------------------------------
   assign in_advance     = in_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | in_advance;
   assign req_take       = req_chan.valid & req_chan.ready;

   assign in_valid_in  = req_take | (in_valid_ff & ~in_advance);
   assign rsp_valid_in = in_advance | (rsp_valid_ff & ~rsp_chan.ready);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   // ---------------------------------------------------------------------------
   // evaluation of the word in the input register
   // ---------------------------------------------------------------------------
   // an unreadable gauge (negative percent) counts as half full
   assign bat_pct = in_word_ff.battery_percent[7] ? bgbc_pkg::UNREADABLE_PERCENT
                                                  : in_word_ff.battery_percent[6:0];
   assign ua             = in_word_ff.charge_current_ua;
   assign stop_current_s = $signed({1'b0, stop_current_ua_ff});

   // gaps are measured with 32-bit wrap
   assign check_age      = in_word_ff.now_seconds - last_check_time_ff;
   assign workaround_age = in_word_ff.now_seconds - last_workaround_time_ff;
   assign check_due      = charge_control_enable_ff & (check_age > bgbc_pkg::CHECK_GAP);
   assign workaround_due = workaround_age > bgbc_pkg::WORKAROUND_GAP;
   assign charger_on     = in_word_ff.charger_status == bgbc_pkg::STATUS_ENABLED;

   always_comb begin
      rsp_word_in                 = '0;
      rsp_word_in.charger_write   = bgbc_pkg::CHG_NONE;
      rsp_word_in.led_level       = bgbc_pkg::LED_NONE;
      rsp_word_in.next_alarm      = bgbc_pkg::NEXT_KEEP;
      warned_mid                  = shutdown_warned_ff;
      blink_phase_in              = blink_phase_ff;
      last_check_time_in          = last_check_time_ff;
      last_workaround_time_in     = last_workaround_time_ff;

      // critical shutdown one-shot, re-armed by charging current
      if ((bat_pct <= shutdown_threshold_ff) && shutdown_enable_ff) begin
         if (ua > bgbc_pkg::CHARGING_UA) begin
            warned_mid = 1'b0;
         end else if (!shutdown_warned_ff) begin
            warned_mid                   = 1'b1;
            rsp_word_in.shutdown_request = 1'b1;
         end
      end

      // charger hysteresis; a later workaround enable overrides a disable
      if (check_due) begin
         if (in_word_ff.charger_status[1]) begin
            rsp_word_in.charger_read_error = 1'b1;
         end else begin
            if (charger_on && (bat_pct >= stop_capacity_ff) && (ua > 0) &&
                (ua < stop_current_s)) begin
               rsp_word_in.charger_write = bgbc_pkg::CHG_DISABLE;
            end else if (!charger_on && (bat_pct <= start_capacity_ff)) begin
               rsp_word_in.charger_write = bgbc_pkg::CHG_ENABLE;
            end
            if ((bat_pct <= start_capacity_ff) && workaround_due) begin
               rsp_word_in.charger_write = bgbc_pkg::CHG_ENABLE;
               last_workaround_time_in   = in_word_ff.now_seconds;
            end
         end
         // read failures still advance the check time
         last_check_time_in = in_word_ff.now_seconds;
      end

      // blink sequencer
      shutdown_warned_in = warned_mid;
      case (blink_phase_ff)
         BLINK_IDLE: begin
            if ((bat_pct <= warn_threshold_ff) && (ua < 0)) begin
               blink_phase_in         = BLINK_WAIT_ON;
               rsp_word_in.next_alarm = bgbc_pkg::NEXT_BLINK_OFF;
            end
         end
         BLINK_WAIT_ON: begin
            if (ua > 0) begin
               // charging ends the warning and re-arms shutdown
               shutdown_warned_in     = 1'b0;
               blink_phase_in         = BLINK_IDLE;
               rsp_word_in.next_alarm = bgbc_pkg::NEXT_CHECK;
               rsp_word_in.led_write  = 1'b1;
               rsp_word_in.led_level  = bgbc_pkg::LED_NORMAL;
            end else begin
               blink_phase_in         = BLINK_LED_ON;
               rsp_word_in.next_alarm = bgbc_pkg::NEXT_BLINK_ON;
               rsp_word_in.led_write  = 1'b1;
               rsp_word_in.led_level  = bgbc_pkg::LED_BLINK_ON;
            end
         end
         default: begin
            // led on; the unused code behaves the same
            if (ua > 0) begin
               shutdown_warned_in     = 1'b0;
               blink_phase_in         = BLINK_IDLE;
               rsp_word_in.next_alarm = bgbc_pkg::NEXT_CHECK;
               rsp_word_in.led_write  = 1'b1;
               rsp_word_in.led_level  = bgbc_pkg::LED_NORMAL;
            end else begin
               blink_phase_in         = BLINK_WAIT_ON;
               rsp_word_in.next_alarm = bgbc_pkg::NEXT_BLINK_OFF;
               rsp_word_in.led_write  = 1'b1;
               rsp_word_in.led_level  = bgbc_pkg::LED_BLINK_OFF;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         blink_phase_ff          <= BLINK_IDLE;
         shutdown_warned_ff      <= 1'b0;
         last_check_time_ff      <= '0;
         last_workaround_time_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // state moves only when a word is evaluated
         if (in_advance) begin
            blink_phase_ff          <= blink_phase_in;
            shutdown_warned_ff      <= shutdown_warned_in;
            last_check_time_ff      <= last_check_time_in;
            last_workaround_time_ff <= last_workaround_time_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_chan.data;
      end
      if (in_advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         warn_threshold_ff        <= bgbc_pkg::WARN_THRESHOLD_RST;
         shutdown_threshold_ff    <= bgbc_pkg::SHUTDOWN_THRESHOLD_RST;
         shutdown_enable_ff       <= 1'b0;
         charge_control_enable_ff <= 1'b0;
         stop_capacity_ff         <= bgbc_pkg::STOP_CAPACITY_RST;
         stop_current_ua_ff       <= bgbc_pkg::STOP_CURRENT_UA_RST;
         start_capacity_ff        <= bgbc_pkg::START_CAPACITY_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            bgbc_pkg::CSR_WARN_THRESHOLD: begin
               warn_threshold_ff <= csr_write_data[bgbc_pkg::PCT_W-1:0];
            end
            bgbc_pkg::CSR_SHUTDOWN_THRESHOLD: begin
               shutdown_threshold_ff <= csr_write_data[bgbc_pkg::PCT_W-1:0];
            end
            bgbc_pkg::CSR_SHUTDOWN_ENABLE: begin
               shutdown_enable_ff <= csr_write_data[0];
            end
            bgbc_pkg::CSR_CHARGE_CTRL_ENABLE: begin
               charge_control_enable_ff <= csr_write_data[0];
            end
            bgbc_pkg::CSR_STOP_CAPACITY: begin
               stop_capacity_ff <= csr_write_data[bgbc_pkg::PCT_W-1:0];
            end
            bgbc_pkg::CSR_STOP_CURRENT_UA: begin
               stop_current_ua_ff <= csr_write_data;
            end
            bgbc_pkg::CSR_START_CAPACITY: begin
               start_capacity_ff <= csr_write_data[bgbc_pkg::PCT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   // an evaluated word always lands in the result register
   `BGBC_ASSERT_NEXT(a_eval_lands, in_advance, rsp_valid_ff)
   // every led write comes with a timer reload
   `BGBC_ASSERT_NOW(a_led_reload, rsp_valid_ff && rsp_word_ff.led_write,
                    rsp_word_ff.next_alarm != bgbc_pkg::NEXT_KEEP)
   // a failed readback never produces a charger command
   `BGBC_ASSERT_NOW(a_rderr_no_cmd, rsp_valid_ff && rsp_word_ff.charger_read_error,
                    rsp_word_ff.charger_write == bgbc_pkg::CHG_NONE)

endmodule

@@ test/guard_checker_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// guard_checker_pkg
// outcome predictor and result checker for the battery guard block
// ----------------------------------------------------------------------------
package guard_checker_pkg;
   import bgbc_pkg::*;

   // charger readback codes not named by the block package
   localparam logic [1:0] STATUS_DISABLED    = 2'd0;
   localparam logic [1:0] STATUS_READ_FAILED = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN     = 2'd3;

   // register index that maps to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   localparam int REPORT_LIMIT = 10;

   typedef enum logic [1:0] {
      BLINK_IDLE    = 2'd0,
      BLINK_WAIT_ON = 2'd1,
      BLINK_LIT     = 2'd2
   } blink_phase_e;

   class guard_checker;
      // register copies
      int warn_pct;
      int shutdown_pct;
      bit shutdown_on;
      bit charge_ctrl_on;
      int stop_pct;
      int stop_ua;
      int start_pct;
      // block state copies
      blink_phase_e blink;
      bit warned;
      logic [TIME_W-1:0] last_check_s;
      logic [TIME_W-1:0] last_workaround_s;
      rsp_word_type pending_outcomes[$];
      int errors;

      function new();
         warn_pct = int'(WARN_THRESHOLD_RST);
         shutdown_pct = int'(SHUTDOWN_THRESHOLD_RST);
         shutdown_on = 1'b0;
         charge_ctrl_on = 1'b0;
         stop_pct = int'(STOP_CAPACITY_RST);
         stop_ua = int'(STOP_CURRENT_UA_RST);
         start_pct = int'(START_CAPACITY_RST);
         blink = BLINK_IDLE;
         warned = 1'b0;
         last_check_s = '0;
         last_workaround_s = '0;
         errors = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_WARN_THRESHOLD:     warn_pct = int'(value[PCT_W-1:0]);
            CSR_SHUTDOWN_THRESHOLD: shutdown_pct = int'(value[PCT_W-1:0]);
            CSR_SHUTDOWN_ENABLE:    shutdown_on = value[0];
            CSR_CHARGE_CTRL_ENABLE: charge_ctrl_on = value[0];
            CSR_STOP_CAPACITY:      stop_pct = int'(value[PCT_W-1:0]);
            CSR_STOP_CURRENT_UA:    stop_ua = int'(value);
            CSR_START_CAPACITY:     start_pct = int'(value[PCT_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_tick(req_word_type w);
         int pct;
         int ua;
         logic [TIME_W-1:0] now;
         bit enabled;
         rsp_word_type o;
         o = '0;
         o.charger_write = CHG_NONE;
         o.led_level = LED_NONE;
         o.next_alarm = NEXT_KEEP;
         pct = int'($signed(w.battery_percent));
         ua = int'($signed(w.charge_current_ua));
         now = w.now_seconds;
         if (pct < 0) pct = int'(UNREADABLE_PERCENT);

         // one-shot shutdown, re-armed by charging current
         if (pct <= shutdown_pct && shutdown_on) begin
            if (ua > int'(CHARGING_UA)) begin
               warned = 1'b0;
            end else if (!warned) begin
               warned = 1'b1;
               o.shutdown_request = 1'b1;
            end
         end

         // charger hysteresis plus periodic re-enable
         if (charge_ctrl_on && (now - last_check_s) > CHECK_GAP) begin
            if (w.charger_status >= STATUS_READ_FAILED) begin
               o.charger_read_error = 1'b1;
            end else begin
               enabled = (w.charger_status == STATUS_ENABLED);
               if (enabled && pct >= stop_pct && ua > 0 && ua < stop_ua)
                  o.charger_write = CHG_DISABLE;
               else if (!enabled && pct <= start_pct)
                  o.charger_write = CHG_ENABLE;
               if (pct <= start_pct && (now - last_workaround_s) > WORKAROUND_GAP) begin
                  o.charger_write = CHG_ENABLE;
                  last_workaround_s = now;
               end
            end
            last_check_s = now;
         end

         // led blink sequence
         if (blink != BLINK_IDLE) begin
            o.led_write = 1'b1;
            if (ua > 0) begin
               warned = 1'b0;
               blink = BLINK_IDLE;
               o.next_alarm = NEXT_CHECK;
               o.led_level = LED_NORMAL;
            end else if (blink == BLINK_WAIT_ON) begin
               blink = BLINK_LIT;
               o.next_alarm = NEXT_BLINK_ON;
               o.led_level = LED_BLINK_ON;
            end else begin
               blink = BLINK_WAIT_ON;
               o.next_alarm = NEXT_BLINK_OFF;
               o.led_level = LED_BLINK_OFF;
            end
         end else if (pct <= warn_pct && ua < 0) begin
            blink = BLINK_WAIT_ON;
            o.next_alarm = NEXT_BLINK_OFF;
         end
         pending_outcomes.push_back(o);
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) $display("%s", msg);
      endfunction

      function void check_outcome(rsp_word_type got);
         rsp_word_type want;
         if (pending_outcomes.size() == 0) begin
            note_error($sformatf("unexpected result word %h", got));
            return;
         end
         want = pending_outcomes.pop_front();
         if (got.shutdown_request !== want.shutdown_request ||
             got.charger_write !== want.charger_write ||
             got.charger_read_error !== want.charger_read_error ||
             got.led_write !== want.led_write ||
             got.led_level !== want.led_level ||
             got.next_alarm !== want.next_alarm)
            note_error($sformatf({"result mismatch: expected shut=%0d chg=%0d rderr=%0d ",
               "led=%0d/%0d next=%0d, got shut=%0d chg=%0d rderr=%0d led=%0d/%0d next=%0d"},
               want.shutdown_request, want.charger_write, want.charger_read_error,
               want.led_write, want.led_level, want.next_alarm,
               got.shutdown_request, got.charger_write, got.charger_read_error,
               got.led_write, got.led_level, got.next_alarm));
      endfunction

      function int outstanding();
         return pending_outcomes.size();
      endfunction

      function int error_total();
         return errors + pending_outcomes.size();
      endfunction
   endclass

endpackage

@@ test/battery_guard_blink_charge_control_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_guard_blink_charge_control_tb
// self-checking bench for the battery guard block: a directed run through
// shutdown, charger and blink corner cases, then random alarm ticks under
// several register settings, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module battery_guard_blink_charge_control_tb;
   import bgbc_pkg::*;
   import guard_checker_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_PHASES   = 6;
   localparam int TICKS_PER_PHASE = 222;
   localparam int SETTLE_CYCLES   = 8;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   bgbc_req_if req_chan();
   bgbc_rsp_if rsp_chan();

   guard_checker board;

   // running alarm clock for the random ticks
   logic [TIME_W-1:0] tick_time;
   // when set, neither side idles
   bit calm;
   int cycle_count;
   int stall_left;
   int phase;
   int n;

   battery_guard_blink_charge_control DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_idle();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // result side: take a word, then maybe stall for a while
   initial begin
      rsp_chan.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            board.check_outcome(rsp_chan.data);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_idle();
         end
      end
   end

   // one alarm tick word, with an optional gap in front of it
   task automatic send_tick(input req_word_type w);
      int gap;
      gap = pick_idle();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_tick(w);
   endtask

   task automatic directed_tick(input int pct, input int ua, input logic [1:0] status,
                                input logic [TIME_W-1:0] now);
      req_word_type w;
      w.battery_percent = pct[7:0];
      w.charge_current_ua = ua[UA_W-1:0];
      w.charger_status = status;
      w.now_seconds = now;
      send_tick(w);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      board.write_register(idx, value);
      @(posedge clock);
   endtask

   // full register set, plus a write to the unmapped index that must be ignored
   task automatic apply_settings(input int warn, input int shut, input int shut_en,
                                 input int chg_en, input int stop_c, input int stop_cur,
                                 input int start_c);
      set_register(CSR_WARN_THRESHOLD, CSR_DATA_W'(warn));
      set_register(CSR_SHUTDOWN_THRESHOLD, CSR_DATA_W'(shut));
      set_register(CSR_SHUTDOWN_ENABLE, CSR_DATA_W'(shut_en));
      set_register(CSR_CHARGE_CTRL_ENABLE, CSR_DATA_W'(chg_en));
      set_register(CSR_STOP_CAPACITY, CSR_DATA_W'(stop_c));
      set_register(CSR_STOP_CURRENT_UA, CSR_DATA_W'(stop_cur));
      set_register(CSR_START_CAPACITY, CSR_DATA_W'(start_c));
      set_register(CSR_UNUSED, CSR_DATA_W'($urandom()));
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and wait for every pending result word
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   // random tick, biased toward thresholds and a mostly rising clock
   function automatic req_word_type random_tick();
      req_word_type w;
      int r;
      int pct;
      int ua;
      r = $urandom_range(0, 99);
      if (r < 60) tick_time = tick_time + $urandom_range(0, 120);
      else if (r < 78) tick_time = tick_time + $urandom_range(1100, 1400);
      else if (r < 88) tick_time = tick_time + $urandom_range(0, 5000);
      else if (r < 95) tick_time = tick_time + ($urandom_range(0, 1) ? 60 : 61);
      else tick_time = $urandom();
      w.now_seconds = tick_time;

      r = $urandom_range(0, 99);
      if (r < 35) pct = $urandom_range(0, 8);
      else if (r < 50) pct = board.stop_pct + $urandom_range(0, 4) - 2;
      else if (r < 65) pct = board.start_pct + $urandom_range(0, 4) - 2;
      else if (r < 70) pct = board.shutdown_pct + $urandom_range(0, 2) - 1;
      else if (r < 82) pct = $urandom_range(0, 100);
      else if (r < 90) pct = -1;
      else pct = $urandom();
      w.battery_percent = pct[7:0];

      r = $urandom_range(0, 99);
      if (r < 28) ua = -int'($urandom_range(1, 5000));
      else if (r < 43) ua = $urandom_range(0, 200);
      else if (r < 63) ua = $urandom_range(1, board.stop_ua + 1000);
      else if (r < 73) ua = board.stop_ua + $urandom_range(0, 2) - 1;
      else if (r < 85) ua = $urandom();
      else ua = $urandom_range(100000, 8388607);
      w.charge_current_ua = ua[UA_W-1:0];

      r = $urandom_range(0, 99);
      if (r < 45) w.charger_status = STATUS_ENABLED;
      else if (r < 85) w.charger_status = STATUS_DISABLED;
      else if (r < 95) w.charger_status = STATUS_READ_FAILED;
      else w.charger_status = STATUS_UNKNOWN;
      return w;
   endfunction

   initial begin
      board = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      calm = 1'b0;
      tick_time = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: stop below start so disable and re-enable can meet
      apply_settings(5, 1, 1, 1, 90, 80000, 95);
      // unreadable percent, check due, nothing to do
      directed_tick(-1, 0, STATUS_ENABLED, 61);
      // full and trickle charging: disable
      directed_tick(100, 50000, STATUS_ENABLED, 122);
      // percent above 100, current at stop level: no disable
      directed_tick(127, 80000, STATUS_ENABLED, 183);
      // disabled just above start level, then at it
      directed_tick(96, 0, STATUS_DISABLED, 244);
      directed_tick(95, 0, STATUS_DISABLED, 305);
      // failed readbacks, both codes
      directed_tick(80, 0, STATUS_READ_FAILED, 366);
      directed_tick(80, 0, STATUS_UNKNOWN, 427);
      // gap of exactly 60 s: check skipped
      directed_tick(80, 0, STATUS_DISABLED, 487);
      // disable and workaround together reports enable
      directed_tick(92, 1000, STATUS_ENABLED, 1300);
      directed_tick(92, 1000, STATUS_ENABLED, 1361);
      // shutdown one-shot, then blink sequence
      directed_tick(1, 0, STATUS_ENABLED, 1400);
      directed_tick(0, -5, STATUS_ENABLED, 1410);
      directed_tick(0, -1, STATUS_ENABLED, 1420);
      directed_tick(-128, -8388608, STATUS_DISABLED, 1430);
      // 100 uA does not re-arm, charging ends blinking
      directed_tick(1, 100, STATUS_ENABLED, 1440);
      directed_tick(1, 101, STATUS_ENABLED, 1450);
      directed_tick(1, 0, STATUS_ENABLED, 1460);
      directed_tick(1, 8388607, STATUS_ENABLED, 1470);
      // time wrap around the top of the 32-bit range
      directed_tick(2, -1, STATUS_ENABLED, 32'hFFFF_FFF0);
      directed_tick(5, 0, STATUS_DISABLED, 32'h0000_0020);
      directed_tick(6, 0, STATUS_DISABLED, 32'h0000_002D);
      directed_tick(6, 1, STATUS_ENABLED, 32'h0000_0100);
      // warn threshold boundary, then current just under stop level
      directed_tick(5, -1, STATUS_ENABLED, 32'h0000_0110);
      directed_tick(95, 79999, STATUS_ENABLED, 32'h0000_0200);
      tick_time = 32'h0000_0200;

      // random part, one register setting per phase
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         case (phase)
            0: apply_settings(5, 1, 1, 1, 99, 80000, 95);
            1: apply_settings(0, 0, 0, 0, 0, 0, 0);
            2: apply_settings(100, 100, 1, 1, 100, 8388607, 100);
            default: apply_settings($urandom_range(0, 20), $urandom_range(0, 10),
                                    int'($urandom_range(0, 3) != 0),
                                    int'($urandom_range(0, 3) != 0),
                                    $urandom_range(0, 100), $urandom_range(0, 200000),
                                    $urandom_range(0, 100));
         endcase
         // some phases start close to the time wrap
         if ($urandom_range(0, 2) == 0) tick_time = 32'hFFFF_FFFF - $urandom_range(0, 3000);
         for (n = 0; n < TICKS_PER_PHASE; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(0, 4) == 0);
            send_tick(random_tick());
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.error_total() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
